[rtl/cofdet_pkg.sv]
// Package for the cofactor determinant block.
// Holds the sequencer state type, sizes and the permutation table; no dependencies.
package cofdet_pkg;

  localparam int MATRIX_DIM = 4;
  localparam int CELLS      = MATRIX_DIM * MATRIX_DIM;
  localparam int NUM_PERMS  = 24;
  localparam int ELEM_W     = 12;
  localparam int PROD_W     = 48;
  localparam int DET_W      = 64;
  localparam int SIZE_W     = 3;
  // 1.0 in Q4.8, used on the padded diagonal
  localparam logic signed [ELEM_W:0] ONE_Q48 = 13'sd256;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } cofdet_state_t;

  // Permutations of four columns in lexicographic order.
  // Returns {odd, col for row 3, row 2, row 1, row 0}.
  function automatic logic [8:0] perm_entry(input logic [4:0] idx);
    logic [8:0] e;
    case (idx)
      5'd0:  e = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
      5'd1:  e = {1'b1, 2'd2, 2'd3, 2'd1, 2'd0};
      5'd2:  e = {1'b1, 2'd3, 2'd1, 2'd2, 2'd0};
      5'd3:  e = {1'b0, 2'd1, 2'd3, 2'd2, 2'd0};
      5'd4:  e = {1'b0, 2'd2, 2'd1, 2'd3, 2'd0};
      5'd5:  e = {1'b1, 2'd1, 2'd2, 2'd3, 2'd0};
      5'd6:  e = {1'b1, 2'd3, 2'd2, 2'd0, 2'd1};
      5'd7:  e = {1'b0, 2'd2, 2'd3, 2'd0, 2'd1};
      5'd8:  e = {1'b0, 2'd3, 2'd0, 2'd2, 2'd1};
      5'd9:  e = {1'b1, 2'd0, 2'd3, 2'd2, 2'd1};
      5'd10: e = {1'b1, 2'd2, 2'd0, 2'd3, 2'd1};
      5'd11: e = {1'b0, 2'd0, 2'd2, 2'd3, 2'd1};
      5'd12: e = {1'b0, 2'd3, 2'd1, 2'd0, 2'd2};
      5'd13: e = {1'b1, 2'd1, 2'd3, 2'd0, 2'd2};
      5'd14: e = {1'b1, 2'd3, 2'd0, 2'd1, 2'd2};
      5'd15: e = {1'b0, 2'd0, 2'd3, 2'd1, 2'd2};
      5'd16: e = {1'b0, 2'd1, 2'd0, 2'd3, 2'd2};
      5'd17: e = {1'b1, 2'd0, 2'd1, 2'd3, 2'd2};
      5'd18: e = {1'b1, 2'd2, 2'd1, 2'd0, 2'd3};
      5'd19: e = {1'b0, 2'd1, 2'd2, 2'd0, 2'd3};
      5'd20: e = {1'b0, 2'd2, 2'd0, 2'd1, 2'd3};
      5'd21: e = {1'b1, 2'd0, 2'd2, 2'd1, 2'd3};
      5'd22: e = {1'b1, 2'd1, 2'd0, 2'd2, 2'd3};
      5'd23: e = {1'b0, 2'd0, 2'd1, 2'd2, 2'd3};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

[rtl/cofactor_determinant.sv]
// Top level of the cofactor determinant block: load, permutation sequencer, output register.
// Depends on cofdet_pkg.
//
//  channel | ports                              | direction
//  input   | in_valid, in_stall, in_element     | one matrix element per beat, row-major
//  result  | out_valid, out_stall, out_det_value| one determinant per matrix
//  config  | cfg_wr_en, cfg_wr_data             | matrix size, write only
//
// The last element starts the expansion: 24 permutation terms, each built row by row in the
// multiply state and then added or subtracted in the accumulate state on one shared 48x13
// multiplier; all terms run at every size (smaller matrices are padded with identity).
// Input is stalled from the last element until the result beat is taken.
// Reset (rst_n low, synchronous) sets size 4 and clears the load count.
module cofactor_determinant
  import cofdet_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [SIZE_W-1:0]        cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ELEM_W-1:0] in_element,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DET_W-1:0]  out_det_value
);

  cofdet_state_t state_r, state_nxt;
  logic [SIZE_W-1:0]        size_r;
  logic [4:0]               load_cnt_r;
  logic [4:0]               perm_r;
  logic [1:0]               step_r;
  logic signed [ELEM_W-1:0] store_r [CELLS];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [DET_W-1:0]  acc_r;

  logic [2:0]               n_eff;
  logic [4:0]               nn;
  logic                     in_beat;
  logic                     last_elem;
  logic [8:0]               perm_e;
  logic [1:0]               col;
  logic [3:0]               addr;
  logic signed [ELEM_W:0]   elem;
  logic signed [PROD_W+ELEM_W:0] prod_full;
  logic                     load_run, mul_run, acc_run, out_run;

  // saturate the size register to 1..4
  always_comb begin
    if (size_r == 3'd0) n_eff = 3'd1;
    else if (size_r > 3'(MATRIX_DIM)) n_eff = 3'(MATRIX_DIM);
    else n_eff = size_r;
  end
  assign nn = 5'(n_eff) * 5'(n_eff);

  // sequencer outputs
  always_comb begin
    load_run = 1'b0;
    mul_run  = 1'b0;
    acc_run  = 1'b0;
    out_run  = 1'b0;
    unique case (state_r)
      ST_LOAD: load_run = 1'b1;
      ST_MUL:  mul_run  = 1'b1;
      ST_ACC:  acc_run  = 1'b1;
      ST_OUT:  out_run  = 1'b1;
      default: ;
    endcase
  end

  assign in_stall  = !load_run;
  assign out_valid = out_run;
  assign in_beat   = in_valid && load_run;
  assign last_elem = (load_cnt_r + 5'd1) == nn;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (in_beat && last_elem) state_nxt = ST_MUL;
      ST_MUL:  if (step_r == 2'd3) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (perm_r == 5'(NUM_PERMS - 1)) ? ST_OUT : ST_MUL;
      ST_OUT:  if (!out_stall) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // element for the current row under the current permutation; identity padding
  assign perm_e = perm_entry(perm_r);
  assign col    = perm_e[2*step_r +: 2];
  assign addr   = 4'(step_r) * 4'(n_eff) + 4'(col);
  always_comb begin
    if ((3'(step_r) < n_eff) && (3'(col) < n_eff))
      elem = (ELEM_W+1)'(store_r[addr]);
    else if (col == step_r)
      elem = ONE_Q48;
    else
      elem = '0;
  end

  assign prod_full = prod_r * elem;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      size_r     <= 3'(MATRIX_DIM);
      load_cnt_r <= '0;
      perm_r     <= '0;
      step_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        size_r     <= cfg_wr_data;
        load_cnt_r <= '0;
      end else if (in_beat) begin
        load_cnt_r <= last_elem ? 5'd0 : load_cnt_r + 5'd1;
      end
      if (mul_run) step_r <= step_r + 2'd1;
      if (acc_run) perm_r <= (perm_r == 5'(NUM_PERMS - 1)) ? 5'd0 : perm_r + 5'd1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_beat) store_r[load_cnt_r[3:0]] <= in_element;
    if (in_beat && last_elem) begin
      prod_r <= PROD_W'(1);
      acc_r  <= '0;
    end else if (mul_run) begin
      prod_r <= prod_full[PROD_W-1:0];
    end else if (acc_run) begin
      acc_r  <= perm_e[8] ? acc_r - DET_W'(prod_r) : acc_r + DET_W'(prod_r);
      prod_r <= PROD_W'(1);
    end
  end

  assign out_det_value = acc_r;

endmodule

[rtl/cofactor_determinant_checker.sv]
// Port-level checker for the cofactor determinant block, bound to the top level.
// Depends on cofdet_pkg.
module cofactor_determinant_checker
  import cofdet_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DET_W-1:0]  out_det_value
);

  // no element is taken while a result waits
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
    else $error("input open while result pending");

  // result leaves after its beat
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result repeated");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_det_value))
    else $error("stalled result changed");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind cofactor_determinant cofactor_determinant_checker u_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_det_value(out_det_value)
);

[verif/cofactor_determinant_tb.sv]
// Testbench for cofactor_determinant: a queued driver, a result monitor and a determinant predictor.
// Depends on cofdet_pkg and the cofactor_determinant RTL.
module cofactor_determinant_tb;
  import cofdet_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int HOLD_START   = 3000;
  localparam int HOLD_LEN     = 600;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [SIZE_W-1:0]        cfg_wr_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [ELEM_W-1:0] in_element;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DET_W-1:0]  out_det_value;

  cofactor_determinant dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_element(in_element),
    .out_valid(out_valid), .out_stall(out_stall), .out_det_value(out_det_value)
  );

  // Pending elements, expected determinants, bookkeeping
  logic signed [ELEM_W-1:0] elem_q[$];
  logic signed [DET_W-1:0]  det_q[$];
  int  errors = 0;
  int  cycles = 0;
  int  dets_seen = 0;
  int  beats_in = 0;
  bit  in_taken;

  // Predictor state
  logic [SIZE_W-1:0]        size_reg;
  logic signed [ELEM_W-1:0] cells[CELLS];
  int                       fill;

  function automatic int used_size(logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MATRIX_DIM) return MATRIX_DIM;
    return int'(s);
  endfunction

  // Laplace expansion of rows row..n-1 over the columns flagged in cols
  function automatic longint minor_det(int n, int row, logic [3:0] cols);
    longint acc;
    longint term;
    int     pos;
    acc = 0;
    pos = 0;
    if (row >= n) return 1;
    for (int c = 0; c < n; c++) begin
      if (cols[c]) begin
        term = longint'(cells[row * n + c]) * minor_det(n, row + 1, cols & ~(4'b1 << c));
        if (pos[0]) acc -= term;
        else acc += term;
        pos++;
      end
    end
    return acc;
  endfunction

  task automatic take_element(logic signed [ELEM_W-1:0] e);
    int     n;
    longint d;
    n = used_size(size_reg);
    if (fill >= n * n) fill = 0;
    cells[fill] = e;
    fill++;
    if (fill == n * n) begin
      fill = 0;
      d = minor_det(n, 0, 4'((1 << n) - 1));
      d = d <<< (32 - 8 * n);
      det_q.push_back(d);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("cofactor_determinant_tb failed");
      $finish;
    end
  end

  // Input beats and config writes feed the predictor; results are checked
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_wr_en) begin
        size_reg = cfg_wr_data;
        fill = 0;
      end
      if (in_valid && !in_stall) begin
        take_element(in_element);
        beats_in++;
      end
      if (out_valid && !out_stall) begin
        dets_seen++;
        if (det_q.size() == 0) begin
          $error("det_value: none expected, actual %0d", out_det_value);
          errors++;
        end else begin
          if (out_det_value !== det_q[0]) begin
            $error("det_value: expected %0d, actual %0d", det_q[0], out_det_value);
            errors++;
          end
          void'(det_q.pop_front());
        end
      end
    end
  end

  // Driver: bursts of beats with random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled beat holds
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (elem_q.size() > 0) begin
      in_element <= elem_q.pop_front();
      in_valid <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall pattern, with one long hold-off timed by its own counter
  int stall_mode = 0;
  int rx_cycles = 0;
  always @(negedge clk) begin
    if (rx_cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN) out_stall <= 1'b1;
    else if (stall_mode == 0) out_stall <= 1'b0;
    else if (stall_mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else if (stall_mode == 2) out_stall <= ($urandom_range(0, 1) == 0);
    else out_stall <= ($urandom_range(0, 7) != 0);
    rx_cycles++;
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (elem_q.size() != 0 || in_valid || det_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] s);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= s;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 12'sh7FF;
      1: return -12'sh800;
      2: return 12'sd256;
      3: return '0;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  task automatic push_matrix(int n, int kind);
    for (int k = 0; k < n * n; k++) begin
      case (kind)
        0: elem_q.push_back(12'sh7FF);
        1: elem_q.push_back(-12'sh800);
        2: elem_q.push_back((k % (n + 1) == 0) ? 12'sd256 : 12'sd0);
        3: elem_q.push_back((k % 2 == 0) ? 12'sh7FF : -12'sh800);
        default: elem_q.push_back(rand_elem());
      endcase
    end
  endtask

  // Stimulus sequence
  int sizes_hit = 0;
  initial begin
    int sz;
    int n;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_element = '0;
    out_stall = 1'b0;
    size_reg = 3'd4;
    fill = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset size, extremes, identity, then each size
    for (int kind = 0; kind < 4; kind++) push_matrix(4, kind);
    // partial matrix abandoned by a size write
    for (int k = 0; k < 5; k++) elem_q.push_back(rand_elem());
    write_size(3'd1);
    elem_q.push_back(12'sh7FF);
    elem_q.push_back(-12'sh800);
    elem_q.push_back(12'sd0);
    write_size(3'd2);
    push_matrix(2, 2);
    push_matrix(2, 3);
    write_size(3'd0);
    push_matrix(1, 4);
    write_size(3'd7);
    push_matrix(4, 4);
    write_size(3'd3);
    push_matrix(3, 1);

    // Random phases: mostly full matrices, sometimes a trailing partial one
    while (beats_in + elem_q.size() < 1500) begin
      sz = $urandom_range(0, 7);
      write_size(SIZE_W'(sz));
      sizes_hit++;
      n = used_size(SIZE_W'(sz));
      for (int m = $urandom_range(1, (n == 1) ? 10 : 6); m > 0; m--) push_matrix(n, 4);
      if ($urandom_range(0, 3) == 0)
        for (int k = $urandom_range(1, n * n); k > 1; k--) elem_q.push_back(rand_elem());
    end

    wait_idle();
    $display("Covered %0d element beats and %0d determinants over %0d random size phases",
             beats_in, dets_seen, sizes_hit);
    if (errors == 0) begin
      $display("cofactor_determinant_tb passed");
    end else begin
      $display("cofactor_determinant_tb failed");
    end
    $finish;
  end

endmodule
